// File: rtl/vag_pkg.sv
`default_nettype none

package vag_pkg;

  localparam int unsigned MAX_X = 128;
  localparam int unsigned MAX_Y = 128;
  localparam int unsigned MAX_Z = 1024;

  localparam int unsigned HIST_DEPTH = 2 * MAX_X * MAX_Y;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);

  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  localparam int signed DERIV_LIMIT = 131070;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2,
    REG_AXIS   = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    axis_e ax;
    logic  one;
    logic  first;
    logic  near;
    logic  last;
    logic  vend;
  } ctl_t;

  typedef struct packed {
    logic signed [17:0] deriv;
    logic [6:0]         col;
    logic [6:0]         row;
    logic [9:0]         plane;
    logic               last;
    logic               vend;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/volume_axis_gradient_core.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    sample_i
// out       output     out_valid_o / out_stall_i  derivative_o, pos_*_o, last_of_run_o,
//                                                 volume_end_o
// cfg       input      psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// One item per cycle while in_stall_o is low; its results pass the s1, s2 and s3 registers before the queue.
// An item with two results leaves the queue one result at a time, so the output port sets the rate.
// The history memory gives two reads and one write per cycle, one pass per item.
// Reset clears counters, queue and registers; the history memory is not cleared.
// in_stall_o rises when the output queue has no room left for two more results.

module volume_axis_gradient_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [15:0]        sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [17:0]      derivative_o,
  output logic [6:0]              pos_col_o,
  output logic [6:0]              pos_row_o,
  output logic [9:0]              pos_plane_o,
  output logic                    last_of_run_o,
  output logic                    volume_end_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned AW = vag_pkg::HIST_AW;
  localparam int unsigned QW = vag_pkg::FIFO_AW;
  localparam int unsigned CW = vag_pkg::FIFO_CW;

  logic [7:0]  size_x_q, size_y_q;
  logic [10:0] size_z_q;
  logic [1:0]  axis_q;

  logic [7:0]  sx_c, sy_c;
  logic [10:0] sz_c;
  vag_pkg::axis_e ax_c;

  logic [6:0]  cnt_col_q, cnt_col_d;
  logic [6:0]  cnt_row_q, cnt_row_d;
  logic [9:0]  cnt_plane_q, cnt_plane_d;

  logic        accept;
  logic [9:0]  c0;
  logic [10:0] n0;
  vag_pkg::ctl_t ctl0;
  logic [17:0] prod_zy;
  logic [AW-1:0] t0;

  logic        v1_q, v2_q, v3_q;
  logic [15:0] s1_q, s2_q, s3_q;
  logic [6:0]  x1_q, x2_q, x3_q;
  logic [6:0]  y1_q, y2_q, y3_q;
  logic [9:0]  z1_q, z2_q, z3_q;
  vag_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q;
  logic [AW-1:0] t1_q, p2_q;
  logic [AW+7:0] prod_p;
  logic [AW-1:0] sxy_q;
  logic [AW-1:0] stride, addr_a, addr_b;

  logic [15:0] hist_q [vag_pkg::HIST_DEPTH];
  logic [15:0] rda_q, rdb_q;

  logic signed [17:0] diff_a, diff_b, d_two;
  logic [6:0]  qx, qy;
  logic [9:0]  qz;
  vag_pkg::res_t r0, r1;
  logic [1:0]  push_k;

  vag_pkg::res_t fifo_q [vag_pkg::FIFO_DEPTH];
  logic [QW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] credit_q, credit_d;
  logic          pop;
  logic [1:0]    rel;
  logic [1:0]    take;
  vag_pkg::res_t head;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= 8'(vag_pkg::MAX_X);
      size_y_q <= 8'(vag_pkg::MAX_Y);
      size_z_q <= 11'd1;
      axis_q   <= vag_pkg::AXIS_X;
    end else if (psel && penable && pwrite) begin
      case (vag_pkg::reg_e'(paddr[3:2]))
        vag_pkg::REG_SIZE_X: size_x_q <= pwdata[7:0];
        vag_pkg::REG_SIZE_Y: size_y_q <= pwdata[7:0];
        vag_pkg::REG_SIZE_Z: size_z_q <= pwdata[10:0];
        vag_pkg::REG_AXIS:   axis_q   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (vag_pkg::reg_e'(paddr[3:2]))
      vag_pkg::REG_SIZE_X: prdata = {24'd0, size_x_q};
      vag_pkg::REG_SIZE_Y: prdata = {24'd0, size_y_q};
      vag_pkg::REG_SIZE_Z: prdata = {21'd0, size_z_q};
      vag_pkg::REG_AXIS:   prdata = {30'd0, axis_q};
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    if (size_x_q == 8'd0) begin
      sx_c = 8'd1;
    end else if (size_x_q > 8'(vag_pkg::MAX_X)) begin
      sx_c = 8'(vag_pkg::MAX_X);
    end else begin
      sx_c = size_x_q;
    end
    if (size_y_q == 8'd0) begin
      sy_c = 8'd1;
    end else if (size_y_q > 8'(vag_pkg::MAX_Y)) begin
      sy_c = 8'(vag_pkg::MAX_Y);
    end else begin
      sy_c = size_y_q;
    end
    if (size_z_q == 11'd0) begin
      sz_c = 11'd1;
    end else if (size_z_q > 11'(vag_pkg::MAX_Z)) begin
      sz_c = 11'(vag_pkg::MAX_Z);
    end else begin
      sz_c = size_z_q;
    end
    case (axis_q)
      vag_pkg::AXIS_Y: ax_c = vag_pkg::AXIS_Y;
      vag_pkg::AXIS_Z: ax_c = vag_pkg::AXIS_Z;
      default:         ax_c = vag_pkg::AXIS_X;
    endcase
  end

  // accept stage: classify the point, advance the raster counters
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    case (ax_c)
      vag_pkg::AXIS_Y: begin
        c0 = {3'd0, cnt_row_q};
        n0 = {3'd0, sy_c};
      end
      vag_pkg::AXIS_Z: begin
        c0 = cnt_plane_q;
        n0 = sz_c;
      end
      default: begin
        c0 = {3'd0, cnt_col_q};
        n0 = {3'd0, sx_c};
      end
    endcase
    ctl0.ax    = ax_c;
    ctl0.one   = (n0 == 11'd1);
    ctl0.first = (c0 == 10'd0);
    ctl0.near  = (c0 == 10'd1);
    ctl0.last  = ({1'b0, c0} == n0 - 11'd1);
    ctl0.vend  = ({1'b0, cnt_col_q} == sx_c - 8'd1) && ({1'b0, cnt_row_q} == sy_c - 8'd1) &&
                 ({1'b0, cnt_plane_q} == sz_c - 11'd1);
    prod_zy = cnt_plane_q * sy_c;
    t0      = prod_zy[AW-1:0] + {{(AW-7){1'b0}}, cnt_row_q};
  end

  always_comb begin
    cnt_col_d   = cnt_col_q;
    cnt_row_d   = cnt_row_q;
    cnt_plane_d = cnt_plane_q;
    if (({1'b0, cnt_col_q} + 8'd1) >= sx_c) begin
      cnt_col_d = 7'd0;
      if (({1'b0, cnt_row_q} + 8'd1) >= sy_c) begin
        cnt_row_d = 7'd0;
        if (({1'b0, cnt_plane_q} + 11'd1) >= sz_c) begin
          cnt_plane_d = 10'd0;
        end else begin
          cnt_plane_d = cnt_plane_q + 10'd1;
        end
      end else begin
        cnt_row_d = cnt_row_q + 7'd1;
      end
    end else begin
      cnt_col_d = cnt_col_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_col_q   <= 7'd0;
      cnt_row_q   <= 7'd0;
      cnt_plane_q <= 10'd0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
    end else begin
      if (accept) begin
        cnt_col_q   <= cnt_col_d;
        cnt_row_q   <= cnt_row_d;
        cnt_plane_q <= cnt_plane_d;
      end
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // address stages
  assign prod_p = t1_q * sx_c;

  always_ff @(posedge clk_i) begin
    s1_q   <= sample_i;
    x1_q   <= cnt_col_q;
    y1_q   <= cnt_row_q;
    z1_q   <= cnt_plane_q;
    ctl1_q <= ctl0;
    t1_q   <= t0;

    s2_q   <= s1_q;
    x2_q   <= x1_q;
    y2_q   <= y1_q;
    z2_q   <= z1_q;
    ctl2_q <= ctl1_q;
    p2_q   <= prod_p[AW-1:0] + {{(AW-7){1'b0}}, x1_q};

    s3_q   <= s2_q;
    x3_q   <= x2_q;
    y3_q   <= y2_q;
    z3_q   <= z2_q;
    ctl3_q <= ctl2_q;

    sxy_q  <= AW'({8'd0, sx_c} * {8'd0, sy_c});
  end

  always_comb begin
    case (ctl2_q.ax)
      vag_pkg::AXIS_Y: stride = {{(AW-8){1'b0}}, sx_c};
      vag_pkg::AXIS_Z: stride = sxy_q;
      default:         stride = {{(AW-1){1'b0}}, 1'b1};
    endcase
    addr_a = p2_q - stride;
    addr_b = p2_q - {stride[AW-2:0], 1'b0};
  end

  // history memory: read old contents, write this item's sample
  always_ff @(posedge clk_i) begin
    rda_q <= hist_q[addr_a];
    rdb_q <= hist_q[addr_b];
    if (v2_q) begin
      hist_q[p2_q] <= s2_q;
    end
  end

  // result stage
  always_comb begin
    diff_a = $signed({2'b00, s3_q}) - $signed({2'b00, rda_q});
    diff_b = $signed({2'b00, s3_q}) - $signed({2'b00, rdb_q});
    d_two  = {diff_a[16:0], 1'b0};
    qx = x3_q;
    qy = y3_q;
    qz = z3_q;
    case (ctl3_q.ax)
      vag_pkg::AXIS_Y: qy = y3_q - 7'd1;
      vag_pkg::AXIS_Z: qz = z3_q - 10'd1;
      default:         qx = x3_q - 7'd1;
    endcase

    r1.deriv = d_two;
    r1.col   = x3_q;
    r1.row   = y3_q;
    r1.plane = z3_q;
    r1.last  = 1'b1;
    r1.vend  = ctl3_q.vend;

    if (ctl3_q.one) begin
      r0.deriv = '0;
      r0.col   = x3_q;
      r0.row   = y3_q;
      r0.plane = z3_q;
      r0.last  = 1'b1;
      r0.vend  = ctl3_q.vend;
      push_k   = 2'd1;
    end else begin
      r0.deriv = ctl3_q.near ? d_two : diff_b;
      r0.col   = qx;
      r0.row   = qy;
      r0.plane = qz;
      r0.last  = !ctl3_q.last;
      r0.vend  = ctl3_q.vend && !ctl3_q.last;
      if (ctl3_q.first) begin
        push_k = 2'd0;
      end else if (ctl3_q.last) begin
        push_k = 2'd2;
      end else begin
        push_k = 2'd1;
      end
    end
    if (!v3_q) begin
      push_k = 2'd0;
    end
  end

  // output queue with credit for two results per item in flight
  assign head        = fifo_q[rptr_q];
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign in_stall_o  = (credit_q < CW'(2));

  assign derivative_o  = head.deriv;
  assign pos_col_o     = head.col;
  assign pos_row_o     = head.row;
  assign pos_plane_o   = head.plane;
  assign last_of_run_o = head.last;
  assign volume_end_o  = head.vend;

  always_comb begin
    rel      = v3_q ? (2'd2 - push_k) : 2'd0;
    take     = accept ? 2'd2 : 2'd0;
    count_d  = count_q + {{(CW-2){1'b0}}, push_k} - {{(CW-1){1'b0}}, pop};
    credit_d = credit_q + {{(CW-1){1'b0}}, pop} + {{(CW-2){1'b0}}, rel}
               - {{(CW-2){1'b0}}, take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q   <= '0;
      rptr_q   <= '0;
      count_q  <= '0;
      credit_q <= CW'(vag_pkg::FIFO_DEPTH);
    end else begin
      wptr_q   <= wptr_q + {{(QW-2){1'b0}}, push_k};
      rptr_q   <= rptr_q + {{(QW-1){1'b0}}, pop};
      count_q  <= count_d;
      credit_q <= credit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_k != 2'd0) begin
      fifo_q[wptr_q] <= r0;
    end
    if (push_k == 2'd2) begin
      fifo_q[wptr_q + {{(QW-1){1'b0}}, 1'b1}] <= r1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/vag_checker.sv
`default_nettype none

module vag_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [17:0] derivative_o,
  input wire logic [6:0]         pos_col_o,
  input wire logic [6:0]         pos_row_o,
  input wire logic [9:0]         pos_plane_o,
  input wire logic               last_of_run_o,
  input wire logic               volume_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(derivative_o) &&
    $stable(pos_col_o) && $stable(pos_row_o) && $stable(pos_plane_o) &&
    $stable(last_of_run_o) && $stable(volume_end_o))
    else $error("stalled result changed");

  a_vend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && volume_end_o |-> last_of_run_o)
    else $error("volume end on a result that is not last of its run");

  a_deriv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (derivative_o >= -18'sd131070) && (derivative_o <= 18'sd131070))
    else $error("derivative out of range");

  a_first_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("block not idle after reset");

endmodule

bind volume_axis_gradient_core vag_checker u_vag_checker (.*);

`default_nettype wire

// File: tb/sv/volume_axis_gradient_core_tb.sv
`timescale 1ns / 100ps

module volume_axis_gradient_core_tb;

  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MODE_ITEMS    = 50;
  localparam logic [1:0]  AXIS_CODE3    = 2'd3;

  typedef enum logic {
    ROW_CFG   = 1'b0,
    ROW_VOXEL = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    vag_pkg::reg_e idx;
    logic [31:0]   value;
    logic [15:0]   sample;
    logic          modelled;
    logic [1:0]    n_res;
    vag_pkg::res_t r0;
    vag_pkg::res_t r1;
  } row_t;

  localparam vag_pkg::res_t NO_RES = '0;

  function automatic vag_pkg::res_t grad_item(int d, int unsigned x, int unsigned y,
                                              int unsigned z, logic last, logic vend);
    vag_pkg::res_t r;
    r.deriv = d[17:0];
    r.col   = x[6:0];
    r.row   = y[6:0];
    r.plane = z[9:0];
    r.last  = last;
    r.vend  = vend;
    return r;
  endfunction

  function automatic row_t cfg_row(vag_pkg::reg_e idx, logic [31:0] v);
    row_t t;
    t       = '0;
    t.kind  = ROW_CFG;
    t.idx   = idx;
    t.value = v;
    return t;
  endfunction

  function automatic row_t vox_row(logic [15:0] s);
    row_t t;
    t          = '0;
    t.kind     = ROW_VOXEL;
    t.sample   = s;
    t.modelled = 1'b1;
    return t;
  endfunction

  function automatic row_t vox_fix(logic [15:0] s, logic [1:0] n, vag_pkg::res_t r0,
                                   vag_pkg::res_t r1);
    row_t t;
    t        = '0;
    t.kind   = ROW_VOXEL;
    t.sample = s;
    t.n_res  = n;
    t.r0     = r0;
    t.r1     = r1;
    return t;
  endfunction

  function automatic int unsigned eff_size(int unsigned v, int unsigned mx);
    if (v == 0) return 1;
    return (v > mx) ? mx : v;
  endfunction

  localparam int PLAN_LEN = 43;
  localparam row_t PLAN [PLAN_LEN] = '{
    cfg_row(vag_pkg::REG_SIZE_X, 2), cfg_row(vag_pkg::REG_SIZE_Y, 2),
    cfg_row(vag_pkg::REG_SIZE_Z, 1),
    cfg_row(vag_pkg::REG_AXIS, vag_pkg::AXIS_X),
    vox_fix(16'h0000, 0, NO_RES, NO_RES),
    vox_fix(16'hFFFF, 2, grad_item(131070, 0, 0, 0, 0, 0), grad_item(131070, 1, 0, 0, 1, 0)),
    vox_fix(16'hFFFF, 0, NO_RES, NO_RES),
    vox_fix(16'h0000, 2, grad_item(-131070, 0, 1, 0, 0, 0),
            grad_item(-131070, 1, 1, 0, 1, 1)),
    cfg_row(vag_pkg::REG_SIZE_X, 3), cfg_row(vag_pkg::REG_SIZE_Y, 1),
    vox_row(16'h8001), vox_row(16'h7FFF), vox_row(16'h5A5A),
    cfg_row(vag_pkg::REG_SIZE_X, 2), cfg_row(vag_pkg::REG_SIZE_Y, 2),
    cfg_row(vag_pkg::REG_AXIS, vag_pkg::AXIS_Y),
    vox_row(16'h1234), vox_row(16'hFEDC), vox_row(16'hFFFF), vox_row(16'h0001),
    // zero size register and the spare axis code both collapse to a size-one x axis
    cfg_row(vag_pkg::REG_SIZE_X, 0), cfg_row(vag_pkg::REG_AXIS, AXIS_CODE3),
    vox_fix(16'hABCD, 1, grad_item(0, 0, 0, 0, 1, 0), NO_RES),
    vox_fix(16'h0000, 1, grad_item(0, 0, 1, 0, 1, 1), NO_RES),
    cfg_row(vag_pkg::REG_SIZE_X, 1), cfg_row(vag_pkg::REG_SIZE_Y, 1),
    cfg_row(vag_pkg::REG_SIZE_Z, 3),
    cfg_row(vag_pkg::REG_AXIS, vag_pkg::AXIS_Z),
    vox_row(16'h0000), vox_row(16'hFFFF), vox_row(16'h8000),
    cfg_row(vag_pkg::REG_SIZE_Z, 1),
    vox_fix(16'h4321, 1, grad_item(0, 0, 0, 0, 1, 1), NO_RES),
    cfg_row(vag_pkg::REG_SIZE_X, 4), cfg_row(vag_pkg::REG_SIZE_Y, 2),
    cfg_row(vag_pkg::REG_AXIS, vag_pkg::AXIS_X),
    vox_row(16'h0100), vox_row(16'hF000), vox_row(16'h0FFF),
    // shrink the row under a column counter already past the new size
    cfg_row(vag_pkg::REG_SIZE_X, 2),
    vox_row(16'hC3C3), vox_row(16'h3C3C), vox_row(16'hFFFE)
  };

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [15:0]        sample_i      = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic signed [17:0] derivative_o;
  logic [6:0]         pos_col_o;
  logic [6:0]         pos_row_o;
  logic [9:0]         pos_plane_o;
  logic               last_of_run_o;
  logic               volume_end_o;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [3:0]         paddr         = '0;
  logic [31:0]        pwdata        = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic [7:0]         cfg_size_x = 8'd128;
  logic [7:0]         cfg_size_y = 8'd128;
  logic [10:0]        cfg_size_z = 11'd1;
  logic [1:0]         cfg_axis   = vag_pkg::AXIS_X;
  int unsigned        col_n      = 0;
  int unsigned        row_n      = 0;
  int unsigned        plane_n    = 0;
  logic [15:0]        hist_mem [vag_pkg::HIST_DEPTH];

  vag_pkg::res_t      grad_due_q [$];
  int                 n_mismatch    = 0;
  int                 n_seen        = 0;
  int unsigned        cycle_n       = 0;
  int                 send_idle_pct = 16;
  int                 stall_pct     = 80;

  volume_axis_gradient_core u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sample_i,
    .out_valid_o,
    .out_stall_i,
    .derivative_o,
    .pos_col_o,
    .pos_row_o,
    .pos_plane_o,
    .last_of_run_o,
    .volume_end_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic predict_gradient(input logic [15:0] s, input bit keep);
    int unsigned    sx, sy, sz, c, n, stride, p, qx, qy, qz;
    int             si, a, b, d, k;
    vag_pkg::axis_e ax;
    vag_pkg::res_t  r [2];
    sx = eff_size(cfg_size_x, vag_pkg::MAX_X);
    sy = eff_size(cfg_size_y, vag_pkg::MAX_Y);
    sz = eff_size(cfg_size_z, vag_pkg::MAX_Z);
    ax = (cfg_axis == AXIS_CODE3) ? vag_pkg::AXIS_X : vag_pkg::axis_e'(cfg_axis);
    si = s;
    k  = 0;
    case (ax)
      vag_pkg::AXIS_Y: begin
        c = row_n; n = sy; stride = sx;
      end
      vag_pkg::AXIS_Z: begin
        c = plane_n; n = sz; stride = sx * sy;
      end
      default: begin
        c = col_n; n = sx; stride = 1;
      end
    endcase
    p  = (plane_n * sy + row_n) * sx + col_n;
    qx = col_n;
    qy = row_n;
    qz = plane_n;
    if (n == 1) begin
      r[0] = grad_item(0, qx, qy, qz, 1'b0, 1'b0);
      k    = 1;
    end else if (c >= 1) begin
      a = hist_mem[(p - stride) % vag_pkg::HIST_DEPTH];
      if (c == 1) begin
        d = 2 * (si - a);
      end else begin
        b = hist_mem[(p - 2 * stride) % vag_pkg::HIST_DEPTH];
        d = si - b;
      end
      case (ax)
        vag_pkg::AXIS_Y: qy = qy - 1;
        vag_pkg::AXIS_Z: qz = qz - 1;
        default:         qx = qx - 1;
      endcase
      r[0] = grad_item(d, qx, qy, qz, 1'b0, 1'b0);
      k    = 1;
      if (c == n - 1) begin
        r[1] = grad_item(2 * (si - a), col_n, row_n, plane_n, 1'b0, 1'b0);
        k    = 2;
      end
    end
    hist_mem[p % vag_pkg::HIST_DEPTH] = s;
    if (k > 0) begin
      r[k-1].last = 1'b1;
      r[k-1].vend = (col_n == sx - 1) && (row_n == sy - 1) && (plane_n == sz - 1);
      if (keep) begin
        for (int i = 0; i < k; i++) grad_due_q.push_back(r[i]);
      end
    end
    col_n++;
    if (col_n >= sx) begin
      col_n = 0;
      row_n++;
      if (row_n >= sy) begin
        row_n = 0;
        plane_n++;
        if (plane_n >= sz) plane_n = 0;
      end
    end
  endtask

  task automatic push_voxel(input logic [15:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic feed_voxel(input logic [15:0] s);
    predict_gradient(s, 1'b1);
    push_voxel(s);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (grad_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input vag_pkg::reg_e idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      vag_pkg::REG_SIZE_X: cfg_size_x = v[7:0];
      vag_pkg::REG_SIZE_Y: cfg_size_y = v[7:0];
      vag_pkg::REG_SIZE_Z: cfg_size_z = v[10:0];
      default:             cfg_axis   = v[1:0];
    endcase
  endtask

  task automatic run_volume(input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] vz, input logic [31:0] va, output int fed);
    int unsigned pick;
    logic [15:0] s;
    settle();
    write_reg(vag_pkg::REG_SIZE_X, vx);
    settle();
    write_reg(vag_pkg::REG_SIZE_Y, vy);
    settle();
    write_reg(vag_pkg::REG_SIZE_Z, vz);
    settle();
    write_reg(vag_pkg::REG_AXIS, va);
    fed = eff_size(cfg_size_x, vag_pkg::MAX_X) * eff_size(cfg_size_y, vag_pkg::MAX_Y)
        * eff_size(cfg_size_z, vag_pkg::MAX_Z);
    for (int i = 0; i < fed; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) s = 16'h0000;
      else if (pick == 1) s = 16'hFFFF;
      else s = 16'($urandom_range(0, 65535));
      feed_voxel(s);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("volume_axis_gradient_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    vag_pkg::res_t seen, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{derivative_o, pos_col_o, pos_row_o, pos_plane_o, last_of_run_o, volume_end_o};
      n_seen++;
      if (grad_due_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("result %0d unexpected: d=%0d at (%0d,%0d,%0d) last=%0b end=%0b",
                   n_seen, seen.deriv, seen.col, seen.row, seen.plane, seen.last, seen.vend);
      end else begin
        want = grad_due_q.pop_front();
        if (seen !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"result %0d: expected d=%0d at (%0d,%0d,%0d) last=%0b end=%0b,",
                      " got d=%0d at (%0d,%0d,%0d) last=%0b end=%0b"},
                     n_seen, want.deriv, want.col, want.row, want.plane, want.last,
                     want.vend, seen.deriv, seen.col, seen.row, seen.plane, seen.last,
                     seen.vend);
        end
      end
    end
    out_stall_i <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    int fed, fed_total;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        settle();
        write_reg(PLAN[i].idx, PLAN[i].value);
      end else if (PLAN[i].modelled) begin
        feed_voxel(PLAN[i].sample);
      end else begin
        predict_gradient(PLAN[i].sample, 1'b0);
        if (PLAN[i].n_res > 0) grad_due_q.push_back(PLAN[i].r0);
        if (PLAN[i].n_res > 1) grad_due_q.push_back(PLAN[i].r1);
        push_voxel(PLAN[i].sample);
      end
    end

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          send_idle_pct = 16; stall_pct = 80;
        end
        1: begin
          send_idle_pct = 80; stall_pct = 16;
        end
        default: begin
          send_idle_pct = 0; stall_pct = 0;
        end
      endcase
      if (m == 2) begin
        // oversized registers clamp to the full row and column counts
        run_volume($urandom_range(129, 255), 1, 1, vag_pkg::AXIS_X, fed);
        run_volume(1, $urandom_range(129, 255), 1, vag_pkg::AXIS_Y, fed);
      end
      fed_total = 0;
      while (fed_total < MODE_ITEMS) begin
        run_volume(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5),
                   ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5),
                   ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4),
                   $urandom_range(0, 3), fed);
        fed_total += fed;
      end
    end

    settle();
    if (n_mismatch == 0 && grad_due_q.size() == 0) begin
      $display("volume_axis_gradient_core: match");
    end else begin
      $display("volume_axis_gradient_core: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/vag_pkg.sv
rtl/volume_axis_gradient_core.sv
rtl/vag_checker.sv
tb/sv/volume_axis_gradient_core_tb.sv
